// ===== rtl/tracker_channel_tick_events_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tracker channel-tick event core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRACKER_CHANNEL_TICK_EVENTS_CORE_MACROS_SVH
`define TRACKER_CHANNEL_TICK_EVENTS_CORE_MACROS_SVH

// Same-cycle implication
`define TCTE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCTE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcte_pkg.sv =====
// ----------------------------------------------------------------------------
// tcte_pkg
// Shared types, register indexes and constants of the channel-tick core.
// ----------------------------------------------------------------------------
`default_nettype none

package tcte_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_EMPTY_NOTE = 3'd0;
    localparam logic [2:0] REG_NOTE_OFF   = 3'd1;
    localparam logic [2:0] REG_ARPEGGIO   = 3'd2;
    localparam logic [2:0] REG_CUT        = 3'd3;
    localparam logic [2:0] REG_DELAY      = 3'd4;

    localparam logic [7:0] RST_EMPTY_NOTE = 8'd0;
    localparam logic [7:0] RST_NOTE_OFF   = 8'd255;
    localparam logic [3:0] RST_ARPEGGIO   = 4'd0;
    localparam logic [3:0] RST_CUT        = 4'd12;
    localparam logic [3:0] RST_DELAY      = 4'd13;

    localparam logic [6:0] DEFAULT_VEL = 7'd51;
    localparam logic [6:0] FULL_VEL    = 7'd64;
    localparam logic [8:0] NOTE_CAP    = 9'd127;

    localparam logic KIND_ON  = 1'b0;
    localparam logic KIND_OFF = 1'b1;

    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = 2;
    localparam int EVQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0] empty_note;
        logic [7:0] release_code;
        logic [3:0] arpeggio;
        logic [3:0] cut;
        logic [3:0] delay;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [4:0]  tick;
        logic [7:0]  cell_note;
        logic [7:0]  cell_instrument;
        logic [6:0]  cell_volume;
        logic [7:0]  cell_effect;
        logic [47:0] sample_position;
    } item_t;

    typedef struct packed {
        logic [7:0] held_note;
        logic [7:0] held_instrument;
        logic       effect_active;
        logic [3:0] effect_command;
        logic [3:0] effect_parameter;
        logic [7:0] arp_base_note;
        logic [7:0] arp_last_note;
        logic       delay_pending;
        logic [7:0] delayed_note;
        logic [7:0] delayed_instrument;
        logic [6:0] delayed_velocity;
        logic       cut_pending;
    } chan_state_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  channel;
        logic [7:0]  note;
        logic [7:0]  instrument;
        logic [6:0]  velocity;
        logic [47:0] position;
        logic        last;
    } event_t;

    // Residue of a 5-bit tick modulo three: weights of 2^k mod 3 are 1,2,1,2,1.
    function automatic logic [1:0] tick_mod3(input logic [4:0] t);
        logic [2:0] s;
        logic [1:0] r;
        s = 3'(t[0]) + 3'(t[2]) + 3'(t[4]) + {(2'(t[1]) + 2'(t[3])), 1'b0};
        case (s) inside
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcte_regs.sv =====
// ----------------------------------------------------------------------------
// tcte_regs
// APB configuration registers: note codes and effect command nibbles.
// ----------------------------------------------------------------------------
`default_nettype none

module tcte_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcte_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcte_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcte_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output tcte_pkg::cfg_t                cfg
);
    import tcte_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.empty_note   <= RST_EMPTY_NOTE;
            cfg_reg.release_code <= RST_NOTE_OFF;
            cfg_reg.arpeggio     <= RST_ARPEGGIO;
            cfg_reg.cut          <= RST_CUT;
            cfg_reg.delay        <= RST_DELAY;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EMPTY_NOTE: cfg_reg.empty_note   <= pwdata[7:0];
                REG_NOTE_OFF:   cfg_reg.release_code <= pwdata[7:0];
                REG_ARPEGGIO:   cfg_reg.arpeggio     <= pwdata[3:0];
                REG_CUT:        cfg_reg.cut          <= pwdata[3:0];
                REG_DELAY:      cfg_reg.delay        <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_EMPTY_NOTE: prdata = APB_DATA_W'(cfg_reg.empty_note);
            REG_NOTE_OFF:   prdata = APB_DATA_W'(cfg_reg.release_code);
            REG_ARPEGGIO:   prdata = APB_DATA_W'(cfg_reg.arpeggio);
            REG_CUT:        prdata = APB_DATA_W'(cfg_reg.cut);
            REG_DELAY:      prdata = APB_DATA_W'(cfg_reg.delay);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tcte_step.sv =====
// ----------------------------------------------------------------------------
// tcte_step
// One channel tick: decode the cell, run delay, cut and arpeggio, build events.
// ----------------------------------------------------------------------------
`default_nettype none

module tcte_step (
    input  tcte_pkg::cfg_t        cfg,
    input  tcte_pkg::item_t       item,
    input  logic                  in_range,
    input  tcte_pkg::chan_state_t st,
    output tcte_pkg::chan_state_t st_next,
    output logic [1:0]            ev_count,
    output tcte_pkg::event_t      ev0,
    output tcte_pkg::event_t      ev1
);
    import tcte_pkg::*;

    logic [7:0] instr;
    logic [6:0] vel;
    logic       have_off;
    logic [7:0] off_note;
    logic [7:0] off_instr;
    logic       have_on;
    logic [7:0] on_note;
    logic [7:0] on_instr;
    logic [6:0] on_vel;
    logic [1:0] phase;
    logic [8:0] arp_add;
    logic [8:0] arp_sum;
    logic [7:0] arp_target;
    logic       tick_reached;
    event_t     off_ev;
    event_t     on_ev;

    assign instr = (item.cell_instrument != 8'd0) ? item.cell_instrument : st.held_instrument;
    assign vel   = (item.cell_volume == 7'd0) ? DEFAULT_VEL :
                   ((item.cell_volume > FULL_VEL) ? FULL_VEL : item.cell_volume);

    assign tick_reached = item.tick >= {1'b0, st.effect_parameter};

    assign phase   = tick_mod3(item.tick);
    assign arp_add = (phase == 2'd1) ? {5'd0, st.effect_parameter} :
                     ((phase == 2'd2) ? {4'd0, st.effect_parameter, 1'b0} : 9'd0);
    assign arp_sum    = {1'b0, st.arp_base_note} + arp_add;
    assign arp_target = (arp_sum > NOTE_CAP) ? NOTE_CAP[7:0] : arp_sum[7:0];

    always_comb
    begin
        st_next   = st;
        have_off  = 1'b0;
        off_note  = st.held_note;
        off_instr = st.held_instrument;
        have_on   = 1'b0;
        on_note   = item.cell_note;
        on_instr  = instr;
        on_vel    = vel;

        if (!in_range)
        begin
            st_next = st;
        end
        else if (item.tick == 5'd0)
        begin
            st_next.effect_active    = item.cell_effect != 8'd0;
            st_next.effect_command   = item.cell_effect[7:4];
            st_next.effect_parameter = item.cell_effect[3:0];
            st_next.delay_pending    = 1'b0;
            st_next.cut_pending      = 1'b0;
            if (item.cell_note == cfg.empty_note)
            begin
                if (st_next.effect_active && st_next.effect_command == cfg.arpeggio &&
                    st_next.effect_parameter != 4'd0)
                begin
                    st_next.arp_base_note = st.held_note;
                    st_next.arp_last_note = st.held_note;
                end
            end
            else if (item.cell_note == cfg.release_code)
            begin
                if (st.held_note != 8'd0)
                begin
                    have_off          = 1'b1;
                    st_next.held_note = 8'd0;
                end
            end
            else if (st_next.effect_active && st_next.effect_command == cfg.delay &&
                     st_next.effect_parameter != 4'd0)
            begin
                st_next.delay_pending      = 1'b1;
                st_next.delayed_note       = item.cell_note;
                st_next.delayed_instrument = instr;
                st_next.delayed_velocity   = vel;
            end
            else
            begin
                have_off                = st.held_note != 8'd0;
                have_on                 = 1'b1;
                st_next.held_note       = item.cell_note;
                st_next.held_instrument = instr;
                st_next.arp_base_note   = item.cell_note;
                st_next.arp_last_note   = item.cell_note;
                if (st_next.effect_active && st_next.effect_command == cfg.cut)
                begin
                    st_next.cut_pending = 1'b1;
                end
            end
        end
        else if (st.delay_pending && tick_reached)
        begin
            have_off                = st.held_note != 8'd0;
            have_on                 = 1'b1;
            on_note                 = st.delayed_note;
            on_instr                = st.delayed_instrument;
            on_vel                  = st.delayed_velocity;
            st_next.held_note       = st.delayed_note;
            st_next.held_instrument = st.delayed_instrument;
            st_next.arp_base_note   = st.delayed_note;
            st_next.arp_last_note   = st.delayed_note;
            st_next.delay_pending   = 1'b0;
            if (st.effect_active && st.effect_command == cfg.cut)
            begin
                st_next.cut_pending = 1'b1;
            end
        end
        else if (st.cut_pending && tick_reached)
        begin
            have_off            = st.held_note != 8'd0;
            st_next.held_note   = 8'd0;
            st_next.cut_pending = 1'b0;
        end
        else if (st.effect_active && st.effect_command == cfg.arpeggio &&
                 st.effect_parameter != 4'd0 && st.arp_base_note != 8'd0)
        begin
            if (arp_target != st.arp_last_note)
            begin
                have_off              = 1'b1;
                off_note              = st.arp_last_note;
                have_on               = 1'b1;
                on_note               = arp_target;
                on_instr              = st.held_instrument;
                on_vel                = DEFAULT_VEL;
                st_next.arp_last_note = arp_target;
                st_next.held_note     = arp_target;
            end
        end
    end

    always_comb
    begin
        off_ev.kind       = KIND_OFF;
        off_ev.channel    = item.channel;
        off_ev.note       = off_note;
        off_ev.instrument = off_instr;
        off_ev.velocity   = 7'd0;
        off_ev.position   = item.sample_position;
        off_ev.last       = !have_on;

        on_ev.kind        = KIND_ON;
        on_ev.channel     = item.channel;
        on_ev.note        = on_note;
        on_ev.instrument  = on_instr;
        on_ev.velocity    = on_vel;
        on_ev.position    = item.sample_position;
        on_ev.last        = 1'b1;

        ev0      = have_off ? off_ev : on_ev;
        ev1      = on_ev;
        ev_count = 2'(have_off) + 2'(have_on);
    end

endmodule

`default_nettype wire

// ===== rtl/tcte_event_queue.sv =====
// ----------------------------------------------------------------------------
// tcte_event_queue
// Four-entry event queue; takes up to two events per cycle, sends one beat when head_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tracker_channel_tick_events_core_macros.svh"

module tcte_event_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [1:0]                         push_cnt,
    input  tcte_pkg::event_t                   push_ev0,
    input  tcte_pkg::event_t                   push_ev1,
    output logic                               head_valid,
    input  logic                               head_stall,
    output tcte_pkg::event_t                   head_ev,
    output logic [tcte_pkg::EVQ_CNT_W-1:0]     count
);
    import tcte_pkg::*;

    event_t                entry_reg [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]  rd_ptr_reg;
    logic [EVQ_PTR_W-1:0]  wr_ptr_reg;
    logic [EVQ_CNT_W-1:0]  count_reg;
    logic                  pop;

    assign head_valid = count_reg != '0;
    assign head_ev    = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && !head_stall;
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_ev0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + EVQ_PTR_W'(1)] <= push_ev1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + EVQ_PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + EVQ_PTR_W'(pop);
            count_reg  <= count_reg + EVQ_CNT_W'(push_cnt) - EVQ_CNT_W'(pop);
        end
    end

    `TCTE_ASSERT_NOW(a_evq_no_overflow, push_cnt != 2'd0, (4'(count_reg) + 4'(push_cnt)) <= 4'(EVQ_DEPTH), "event queue overflow")
    `TCTE_ASSERT_NOW(a_evq_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty queue with pointers apart")
    `TCTE_ASSERT_NEXT(a_evq_count_track, 1'b1, count_reg == EVQ_CNT_W'($past(count_reg) + EVQ_CNT_W'($past(push_cnt)) - EVQ_CNT_W'($past(pop))), "queue count out of step")

endmodule

`default_nettype wire

// ===== rtl/tracker_channel_tick_events_core.sv =====
// ----------------------------------------------------------------------------
// tracker_channel_tick_events_core
// Per-channel note sequencer: one tick item in, up to two note events out.
//
//   channel   | handshake              | beat carries
//   ----------+------------------------+-------------------------------------
//   item      | item_valid/item_stall  | channel, tick, cell fields, position
//   event     | event_valid/event_stall| kind, channel, note, instr, vel, last
//   config    | APB, pready tied high  | five code registers at 4*i
//
// An accepted item reads the channel state memory; in the next cycle the step
// logic writes the next state back and pushes 0, 1 or 2 events into a
// four-entry queue. The first event can leave once the queue holds it.
// Sustained rate is set by the event port, one beat per cycle while
// event_stall is low; an item that makes two events needs two beats.
// Reset clears all channel state at once through per-channel valid bits.
// item_stall rises while the queue, after the step stage's own push, lacks
// room for two more events.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tracker_channel_tick_events_core_macros.svh"

module tracker_channel_tick_events_core #(
    parameter int CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcte_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcte_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcte_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // tick items
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [2:0]                      channel,
    input  logic [4:0]                      tick,
    input  logic [7:0]                      cell_note,
    input  logic [7:0]                      cell_instrument,
    input  logic [6:0]                      cell_volume,
    input  logic [7:0]                      cell_effect,
    input  logic [47:0]                     sample_position,
    // note events
    output logic                            event_valid,
    input  logic                            event_stall,
    output logic                            event_kind,
    output logic [2:0]                      event_channel,
    output logic [7:0]                      event_note,
    output logic [7:0]                      event_instrument,
    output logic [6:0]                      event_velocity,
    output logic [47:0]                     event_position,
    output logic                            last_event
);
    import tcte_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cfg_t                 cfg;
    item_t                in_item;
    logic                 item_accept;
    logic                 in_range;
    logic [IDX_W-1:0]     rd_idx;

    // state memory and per-channel valid bits
    chan_state_t          state_mem [CHANNELS];
    logic [CHANNELS-1:0]  ch_valid_reg;

    // step stage
    logic                 s1_valid_reg;
    item_t                s1_item_reg;
    logic                 s1_inrange_reg;
    chan_state_t          rd_data_reg;
    logic                 rd_valid_reg;
    logic                 byp_reg;
    logic                 byp_next;
    chan_state_t          byp_data_reg;
    chan_state_t          st_cur;
    chan_state_t          st_next;
    logic                 st_we;
    logic [IDX_W-1:0]     wr_idx;

    logic [1:0]           ev_count;
    event_t               ev0;
    event_t               ev1;
    logic [1:0]           push_cnt;
    event_t               head_ev;
    logic [EVQ_CNT_W-1:0] fifo_count;

    tcte_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        in_item.channel         = channel;
        in_item.tick            = tick;
        in_item.cell_note       = cell_note;
        in_item.cell_instrument = cell_instrument;
        in_item.cell_volume     = cell_volume;
        in_item.cell_effect     = cell_effect;
        in_item.sample_position = sample_position;
    end

    // Hold off a new beat unless the queue can still take two events after
    // the item now in the step stage has pushed its own.
    assign item_stall  = (fifo_count + EVQ_CNT_W'(push_cnt)) > EVQ_CNT_W'(2);
    assign item_accept = item_valid && !item_stall;

    assign in_range = 32'(channel) < CHANNELS;
    assign rd_idx   = IDX_W'(channel);

    assign st_we  = s1_valid_reg && s1_inrange_reg;
    assign wr_idx = IDX_W'(s1_item_reg.channel);

    // Forward the write-back when the next item hits the same channel.
    assign byp_next = item_accept && st_we && (wr_idx == rd_idx);

    // Unwritten channels read as the all-zero reset state.
    assign st_cur = byp_reg ? byp_data_reg : (rd_valid_reg ? rd_data_reg : '0);

    always_ff @(posedge clk)
    begin
        if (item_accept && in_range)
        begin
            rd_data_reg <= state_mem[rd_idx];
        end
        if (st_we)
        begin
            state_mem[wr_idx] <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_item_reg    <= in_item;
            s1_inrange_reg <= in_range;
        end
        if (byp_next)
        begin
            byp_data_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            ch_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= item_accept;
            byp_reg      <= byp_next;
            if (item_accept)
            begin
                rd_valid_reg <= in_range ? ch_valid_reg[rd_idx] : 1'b0;
            end
            if (st_we)
            begin
                ch_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    tcte_step u_step (
        .cfg      (cfg),
        .item     (s1_item_reg),
        .in_range (s1_inrange_reg),
        .st       (st_cur),
        .st_next  (st_next),
        .ev_count (ev_count),
        .ev0      (ev0),
        .ev1      (ev1)
    );

    // Drop the step result when no item occupies the stage.
    assign push_cnt = s1_valid_reg ? ev_count : 2'd0;

    tcte_event_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_ev0   (ev0),
        .push_ev1   (ev1),
        .head_valid (event_valid),
        .head_stall (event_stall),
        .head_ev    (head_ev),
        .count      (fifo_count)
    );

    assign event_kind       = head_ev.kind;
    assign event_channel    = head_ev.channel;
    assign event_note       = head_ev.note;
    assign event_instrument = head_ev.instrument;
    assign event_velocity   = head_ev.velocity;
    assign event_position   = head_ev.position;
    assign last_event       = head_ev.last;

    `TCTE_ASSERT_NEXT(a_accept_enters_step, item_accept, s1_valid_reg, "accepted item missing from step stage")
    `TCTE_ASSERT_NOW(a_bypass_has_source, byp_reg, $past(s1_valid_reg && s1_inrange_reg), "state bypass without write-back")
    `TCTE_ASSERT_NOW(a_step_has_room, s1_valid_reg, fifo_count <= EVQ_CNT_W'(2), "no room for step events")

endmodule

`default_nettype wire
